// ===== rtl/kis_pkg.sv =====
package kis_pkg;

  // Record store geometry.
  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = IDX_W + 1;

  // Field widths.
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned REC_W   = KEY_W + TAG_W;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CAP_W   = 7;
  localparam int unsigned IN_DW   = 48;
  localparam int unsigned OUT_DW  = 56;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 32;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Register index (paddr divided by four).
  localparam logic REG_CAPACITY = 1'b0;

  // Request actions.
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_SORT = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REC   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

endpackage

// ===== rtl/kis_ram.sv =====
module kis_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/keyed_insertion_sorter_core.sv =====
// Keyed insertion sorter: a store of up to 64 records (32-bit area key plus
// 16-bit rectangle tag) held in one single-port-read record RAM.
// Requests arrive on the s_axis channel: tuser selects add (0) or sort (1),
// tdata carries the key and tag. Results leave on the m_axis channel with
// the result kind in tuser and tlast on the final result of each request.
// An add is accepted in the idle state; the execute state then writes the
// record (when there is room) and loads the reply into the output register.
// A sort of n records runs an in-place insertion sort in the RAM: each outer
// step loads a record, then compares it down the sorted part, shifting each
// larger record up a slot; the records are then read out through a read and
// a wait state each, as set by the record RAM's single registered read port.
// A sort of an empty store gives one result of kind 2.
// The capacity register sits at APB address 0; the user must write it only
// while the block is idle, which the block does not enforce. Reset empties
// the store (fill count zero) and sets capacity to 64; the RAM needs no
// clearing pass. A stalled receiver holds the result in the output register
// and the sequencer waits; one new request can still be taken while a reply waits.
module keyed_insertion_sorter_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request channel. tdata: area_key [31:0], rect_tag [47:32].
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [kis_pkg::IN_DW-1:0]        s_axis_tdata_i,
  // tuser: action [0].
  input  logic [0:0]                       s_axis_tuser_i,
  // Result channel. tdata: accepted [0], slot_index [6:1], out_area [38:7],
  // out_tag [54:39], zero fill [55].
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [kis_pkg::OUT_DW-1:0]       m_axis_tdata_o,
  // tuser: kind [1:0].
  output logic [kis_pkg::KIND_W-1:0]       m_axis_tuser_o,
  output logic                             m_axis_tlast_o,
  // Configuration port.
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic [kis_pkg::CFG_AW-1:0]       paddr_i,
  input  logic [kis_pkg::CFG_DW-1:0]       pwdata_i,
  output logic [kis_pkg::CFG_DW-1:0]       prdata_o,
  output logic                             pready_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SRT_LOAD,
    ST_SRT_CMP,
    ST_SRT_PLACE,
    ST_RO_RD,
    ST_RO_WAIT
  } state_e;

  state_e                          state_q;
  logic [kis_pkg::CAP_W-1:0]       capacity_q;
  logic [kis_pkg::CNT_W-1:0]       fill_q;
  logic [kis_pkg::IDX_W-1:0]       j_q;
  logic [kis_pkg::IDX_W-1:0]       i_q;
  logic [kis_pkg::IDX_W-1:0]       p_q;
  logic [kis_pkg::REC_W-1:0]       hold_q;
  logic                            in_act_q;
  logic [kis_pkg::KEY_W-1:0]       in_key_q;
  logic [kis_pkg::TAG_W-1:0]       in_tag_q;

  logic                            m_valid_q;
  logic [kis_pkg::KIND_W-1:0]      m_kind_q;
  logic                            m_acc_q;
  logic [kis_pkg::SLOT_W-1:0]      m_slot_q;
  logic [kis_pkg::KEY_W-1:0]       m_area_q;
  logic [kis_pkg::TAG_W-1:0]       m_tag_q;
  logic                            m_last_q;

  logic                            ram_we;
  logic [kis_pkg::IDX_W-1:0]       ram_waddr;
  logic [kis_pkg::REC_W-1:0]       ram_wdata;
  logic                            ram_re;
  logic [kis_pkg::IDX_W-1:0]       ram_raddr;
  logic [kis_pkg::REC_W-1:0]       ram_rdata;

  logic [kis_pkg::CNT_W-1:0]       eff_cap;
  logic                            room;
  logic                            out_free;
  logic                            in_fire;
  logic                            cfg_wr;
  logic                            greater;
  logic                            done_j;
  logic                            ro_last;

  // Configuration port.
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o
                    && (paddr_i[2] == kis_pkg::REG_CAPACITY);
  assign prdata_o = (paddr_i[2] == kis_pkg::REG_CAPACITY)
                    ? kis_pkg::CFG_DW'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= kis_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      capacity_q <= pwdata_i[kis_pkg::CAP_W-1:0];
    end
  end

  assign eff_cap  = (kis_pkg::CNT_W'(capacity_q) > kis_pkg::CNT_W'(kis_pkg::DEPTH))
                    ? kis_pkg::CNT_W'(kis_pkg::DEPTH) : kis_pkg::CNT_W'(capacity_q);
  assign room     = fill_q < eff_cap;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  // Records hold the key in the low bits and the tag above it.
  assign greater = ram_rdata[kis_pkg::KEY_W-1:0] > hold_q[kis_pkg::KEY_W-1:0];
  assign done_j  = ({1'b0, j_q} + kis_pkg::CNT_W'(1)) == fill_q;
  assign ro_last = ({1'b0, p_q} + kis_pkg::CNT_W'(1)) == fill_q;

  kis_ram #(
    .WIDTH (kis_pkg::REC_W),
    .DEPTH (kis_pkg::DEPTH)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // RAM port control. A shift writes slot i while the next compare reads
  // slot i-2, so the two ports never touch the same entry in one cycle.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state_q)
      ST_EXEC: begin
        if (in_act_q == kis_pkg::ACT_ADD) begin
          if (out_free && room) begin
            ram_we    = 1'b1;
            ram_waddr = fill_q[kis_pkg::IDX_W-1:0];
            ram_wdata = {in_tag_q, in_key_q};
          end
        end else if (fill_q > kis_pkg::CNT_W'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = kis_pkg::IDX_W'(1);
        end
      end
      ST_SRT_LOAD: begin
        ram_re    = 1'b1;
        ram_raddr = j_q - kis_pkg::IDX_W'(1);
      end
      ST_SRT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        if (greater) begin
          ram_wdata = ram_rdata;
          if (i_q != kis_pkg::IDX_W'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = i_q - kis_pkg::IDX_W'(2);
          end
        end else begin
          ram_wdata = hold_q;
          if (!done_j) begin
            ram_re    = 1'b1;
            ram_raddr = j_q + kis_pkg::IDX_W'(1);
          end
        end
      end
      ST_SRT_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = hold_q;
        if (!done_j) begin
          ram_re    = 1'b1;
          ram_raddr = j_q + kis_pkg::IDX_W'(1);
        end
      end
      ST_RO_RD: begin
        ram_re    = 1'b1;
        ram_raddr = p_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      j_q       <= '0;
      i_q       <= '0;
      p_q       <= '0;
      hold_q    <= '0;
      in_act_q  <= kis_pkg::ACT_ADD;
      in_key_q  <= '0;
      in_tag_q  <= '0;
      m_valid_q <= 1'b0;
      m_kind_q  <= kis_pkg::KIND_ADD;
      m_acc_q   <= 1'b0;
      m_slot_q  <= '0;
      m_area_q  <= '0;
      m_tag_q   <= '0;
      m_last_q  <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            in_act_q <= s_axis_tuser_i[0];
            in_key_q <= s_axis_tdata_i[kis_pkg::KEY_W-1:0];
            in_tag_q <= s_axis_tdata_i[kis_pkg::KEY_W +: kis_pkg::TAG_W];
            state_q  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (in_act_q == kis_pkg::ACT_ADD) begin
            if (out_free) begin
              m_valid_q <= 1'b1;
              m_kind_q  <= kis_pkg::KIND_ADD;
              m_acc_q   <= room;
              m_slot_q  <= room ? kis_pkg::SLOT_W'(fill_q) : '0;
              m_area_q  <= '0;
              m_tag_q   <= '0;
              m_last_q  <= 1'b1;
              if (room) begin
                fill_q <= fill_q + kis_pkg::CNT_W'(1);
              end
              state_q <= ST_IDLE;
            end
          end else if (fill_q == '0) begin
            if (out_free) begin
              m_valid_q <= 1'b1;
              m_kind_q  <= kis_pkg::KIND_EMPTY;
              m_acc_q   <= 1'b0;
              m_slot_q  <= '0;
              m_area_q  <= '0;
              m_tag_q   <= '0;
              m_last_q  <= 1'b1;
              state_q   <= ST_IDLE;
            end
          end else if (fill_q == kis_pkg::CNT_W'(1)) begin
            p_q     <= '0;
            state_q <= ST_RO_RD;
          end else begin
            j_q     <= kis_pkg::IDX_W'(1);
            state_q <= ST_SRT_LOAD;
          end
        end
        ST_SRT_LOAD: begin
          hold_q  <= ram_rdata;
          i_q     <= j_q;
          state_q <= ST_SRT_CMP;
        end
        ST_SRT_CMP: begin
          if (greater) begin
            if (i_q == kis_pkg::IDX_W'(1)) begin
              state_q <= ST_SRT_PLACE;
            end else begin
              i_q <= i_q - kis_pkg::IDX_W'(1);
            end
          end else if (done_j) begin
            p_q     <= '0;
            state_q <= ST_RO_RD;
          end else begin
            j_q     <= j_q + kis_pkg::IDX_W'(1);
            state_q <= ST_SRT_LOAD;
          end
        end
        ST_SRT_PLACE: begin
          if (done_j) begin
            p_q     <= '0;
            state_q <= ST_RO_RD;
          end else begin
            j_q     <= j_q + kis_pkg::IDX_W'(1);
            state_q <= ST_SRT_LOAD;
          end
        end
        ST_RO_RD: begin
          state_q <= ST_RO_WAIT;
        end
        ST_RO_WAIT: begin
          // The RAM output holds while no new read is issued.
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_kind_q  <= kis_pkg::KIND_REC;
            m_acc_q   <= 1'b0;
            m_slot_q  <= kis_pkg::SLOT_W'(p_q);
            m_area_q  <= ram_rdata[kis_pkg::KEY_W-1:0];
            m_tag_q   <= ram_rdata[kis_pkg::KEY_W +: kis_pkg::TAG_W];
            m_last_q  <= ro_last;
            if (ro_last) begin
              state_q <= ST_IDLE;
            end else begin
              p_q     <= p_q + kis_pkg::IDX_W'(1);
              state_q <= ST_RO_RD;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tdata_o  = {1'b0, m_tag_q, m_area_q, m_slot_q, m_acc_q};

`ifndef NO_ASSERTIONS
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= kis_pkg::CNT_W'(kis_pkg::DEPTH))
    else $error("fill count exceeds store depth");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(fill_q) |-> fill_q == $past(fill_q) + kis_pkg::CNT_W'(1))
    else $error("fill count changed by other than one");

  a_rec_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_kind_q == kis_pkg::KIND_REC) |->
      kis_pkg::CNT_W'(m_slot_q) < fill_q)
    else $error("sorted record position beyond fill count");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_EXEC)
    else $error("accepted request not executed");
`endif

endmodule

// ===== tb/tb_keyed_insertion_sorter_core.sv =====
`timescale 1ns / 1ps

module tb_keyed_insertion_sorter_core;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned PHASE_REQUESTS = 60;

  typedef struct packed {
    logic [kis_pkg::KIND_W-1:0] kind;
    logic                       accepted;
    logic [kis_pkg::SLOT_W-1:0] slot;
    logic [kis_pkg::KEY_W-1:0]  area;
    logic [kis_pkg::TAG_W-1:0]  tag;
    logic                       last;
  } sorter_result_t;

  // Tracks the record store and the results still owed by the block.
  class record_store_t;
    logic [kis_pkg::KEY_W-1:0] key_mem [kis_pkg::DEPTH];
    logic [kis_pkg::TAG_W-1:0] tag_mem [kis_pkg::DEPTH];
    int unsigned fill;
    int unsigned capacity;
    sorter_result_t pending [$];
    int unsigned errors, stored, refused, sorts, empties, checked;

    function new();
      fill = 0;
      capacity = int'(kis_pkg::CAP_RESET);
      errors = 0;
      stored = 0;
      refused = 0;
      sorts = 0;
      empties = 0;
      checked = 0;
    endfunction

    function void set_capacity(logic [kis_pkg::CAP_W-1:0] value);
      capacity = int'(value);
    endfunction

    // Stable insertion sort: a record only moves past strictly larger keys.
    function void order_records();
      logic [kis_pkg::KEY_W-1:0] key;
      logic [kis_pkg::TAG_W-1:0] tag;
      int unsigned i;
      for (int unsigned j = 1; j < fill; j++) begin
        key = key_mem[j];
        tag = tag_mem[j];
        i = j;
        while (i > 0 && key_mem[i-1] > key) begin
          key_mem[i] = key_mem[i-1];
          tag_mem[i] = tag_mem[i-1];
          i--;
        end
        key_mem[i] = key;
        tag_mem[i] = tag;
      end
    endfunction

    function void note_request(logic act, logic [kis_pkg::KEY_W-1:0] key,
                               logic [kis_pkg::TAG_W-1:0] tag);
      int unsigned limit;
      sorter_result_t r;
      limit = (capacity < kis_pkg::DEPTH) ? capacity : kis_pkg::DEPTH;
      r = '0;
      r.last = 1'b1;
      if (act == kis_pkg::ACT_ADD) begin
        r.kind = kis_pkg::KIND_ADD;
        if (fill < limit) begin
          key_mem[fill] = key;
          tag_mem[fill] = tag;
          r.accepted = 1'b1;
          r.slot = fill[kis_pkg::SLOT_W-1:0];
          fill++;
          stored++;
        end else begin
          refused++;
        end
        pending.push_back(r);
      end else begin
        sorts++;
        if (fill == 0) begin
          r.kind = kis_pkg::KIND_EMPTY;
          empties++;
          pending.push_back(r);
        end else begin
          order_records();
          for (int unsigned p = 0; p < fill; p++) begin
            r.kind = kis_pkg::KIND_REC;
            r.slot = p[kis_pkg::SLOT_W-1:0];
            r.area = key_mem[p];
            r.tag = tag_mem[p];
            r.last = (p + 1 == fill);
            pending.push_back(r);
          end
        end
      end
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("field %s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(sorter_result_t got);
      sorter_result_t want;
      if (pending.size() == 0) begin
        $error("result of kind %0d arrived with nothing outstanding", got.kind);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      compare("kind", 32'(want.kind), 32'(got.kind));
      compare("accepted", 32'(want.accepted), 32'(got.accepted));
      compare("slot_index", 32'(want.slot), 32'(got.slot));
      compare("out_area", want.area, got.area);
      compare("out_tag", 32'(want.tag), 32'(got.tag));
      compare("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         s_axis_tvalid_i = 1'b0;
  logic                         s_axis_tready_o;
  logic [kis_pkg::IN_DW-1:0]    s_axis_tdata_i = '0;
  logic [0:0]                   s_axis_tuser_i = '0;
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i = 1'b0;
  logic [kis_pkg::OUT_DW-1:0]   m_axis_tdata_o;
  logic [kis_pkg::KIND_W-1:0]   m_axis_tuser_o;
  logic                         m_axis_tlast_o;
  logic                         psel_i = 1'b0;
  logic                         penable_i = 1'b0;
  logic                         pwrite_i = 1'b0;
  logic [kis_pkg::CFG_AW-1:0]   paddr_i = '0;
  logic [kis_pkg::CFG_DW-1:0]   pwdata_i = '0;
  logic [kis_pkg::CFG_DW-1:0]   prdata_o;
  logic                         pready_o;

  record_store_t ledger;
  bit            send_calm = 1'b0;
  int unsigned   hold_asks = 0;
  int unsigned   cycle_count = 0;

  keyed_insertion_sorter_core i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, ledger.pending.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_request(input logic act, input logic [kis_pkg::KEY_W-1:0] key,
                              input logic [kis_pkg::TAG_W-1:0] tag);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {tag, key};
    s_axis_tuser_i <= act;
    do @(posedge clk_i); while (!s_axis_tready_o);
    ledger.note_request(act, key, tag);
  endtask

  // Stop offering requests and let every owed result drain.
  task automatic quiesce();
    s_axis_tvalid_i <= 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [kis_pkg::CAP_W-1:0] value);
    quiesce();
    psel_i <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i <= 1'b1;
    paddr_i <= {kis_pkg::REG_CAPACITY, 2'b00};
    pwdata_i <= kis_pkg::CFG_DW'(value);
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    ledger.set_capacity(value);
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    ledger.compare("capacity", kis_pkg::CFG_DW'(value), prdata_o);
    psel_i <= 1'b0;
    penable_i <= 1'b0;
  endtask

  // Full-range keys, a narrow band that forces equal keys, and the extremes.
  function automatic logic [kis_pkg::KEY_W-1:0] draw_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin : result_sink
    int unsigned gap;
    int unsigned holds_seen;
    int unsigned taken;
    bit calm;
    sorter_result_t got;
    holds_seen = 0;
    taken = 0;
    calm = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (holds_seen != hold_asks) begin
        holds_seen = hold_asks;
        gap = LONG_HOLD;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 9);
      end
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got.kind = m_axis_tuser_o;
      got.accepted = m_axis_tdata_o[0];
      got.slot = m_axis_tdata_o[6:1];
      got.area = m_axis_tdata_o[38:7];
      got.tag = m_axis_tdata_o[54:39];
      got.last = m_axis_tlast_o;
      ledger.check_result(got);
      taken++;
      if (taken % 16 == 0) calm = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : stimulus
    int unsigned phase_caps [7];
    logic act;
    ledger = new();
    rst_ni <= 1'b0;
    phase_caps = '{5, 2, 20, 45, 127, 64, 50};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sort with nothing stored, then a capacity of zero that refuses all adds.
    send_request(kis_pkg::ACT_SORT, $urandom, 16'($urandom_range(0, 16'hFFFF)));
    set_capacity(7'd0);
    send_request(kis_pkg::ACT_ADD, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(kis_pkg::ACT_SORT, 32'h0, 16'h0);
    set_capacity(7'd1);
    send_request(kis_pkg::ACT_ADD, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(kis_pkg::ACT_ADD, 32'h1, 16'h1);
    send_request(kis_pkg::ACT_SORT, 32'hFFFF_FFFF, 16'hFFFF);
    // Equal keys must keep the order in which they were added.
    set_capacity(7'd4);
    send_request(kis_pkg::ACT_ADD, 32'h5, 16'h0001);
    send_request(kis_pkg::ACT_ADD, 32'h0, 16'h0000);
    send_request(kis_pkg::ACT_ADD, 32'h5, 16'h0002);
    send_request(kis_pkg::ACT_ADD, 32'h8000_0000, 16'h8000);
    send_request(kis_pkg::ACT_SORT, $urandom, 16'($urandom_range(0, 16'hFFFF)));
    // Capacity below the fill count: adds refused, every record still read out.
    set_capacity(7'd2);
    send_request(kis_pkg::ACT_ADD, 32'h3, 16'h0003);
    send_request(kis_pkg::ACT_SORT, 32'h0, 16'h0);

    foreach (phase_caps[p]) begin
      set_capacity(phase_caps[p][kis_pkg::CAP_W-1:0]);
      if (p == 3 || p == 4) hold_asks++;
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (n % 12 == 0) send_calm = ($urandom_range(0, 3) == 0);
        act = ($urandom_range(0, 7) == 0) ? kis_pkg::ACT_SORT : kis_pkg::ACT_ADD;
        send_request(act, draw_key(), 16'($urandom_range(0, 16'hFFFF)));
      end
    end

    quiesce();
    repeat (20) @(posedge clk_i);
    $display("Ran %0d adds (%0d stored, %0d refused) and %0d sorts (%0d empty).",
             ledger.stored + ledger.refused, ledger.stored, ledger.refused,
             ledger.sorts, ledger.empties);
    $display("Checked %0d results across capacities from 0 to 127; %0d mismatches.",
             ledger.checked, ledger.errors);
    if (ledger.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/kis_pkg.sv
rtl/kis_ram.sv
rtl/keyed_insertion_sorter_core.sv
tb/tb_keyed_insertion_sorter_core.sv
